>>> src/atf_pkg.sv
// ----------------------------------------------------------------------------
// atf_pkg
// Shared types, constants and the sign-magnitude recode for the attitude
// telemetry framer.
// ----------------------------------------------------------------------------
package atf_pkg;

    localparam int unsigned FRAME_LEN  = 18;
    localparam int unsigned NUM_VALUES = 6;
    localparam int unsigned HEAD_LEN   = 4;

    localparam logic [7:0] SYNC_A    = 8'hA5;
    localparam logic [7:0] SYNC_B    = 8'h5A;
    localparam logic [7:0] LEN_BYTE  = 8'h10;
    localparam logic [7:0] ID_BYTE   = 8'hA1;
    localparam logic [7:0] SUM_SEED  = 8'hB1;
    localparam logic [7:0] END_BYTE  = 8'hAA;
    localparam logic [15:0] NEG_BIAS = 16'h8000;

    typedef struct packed {
        logic       valid;
        logic       sum_en;
        logic       csum;
        logic       last;
        logic [7:0] data;
    } t_cell;

    function automatic logic [15:0] to_sign_mag(input logic [15:0] v);
        logic [15:0] r;
        r = v[15] ? (NEG_BIAS - v) : v;
        return r;
    endfunction

endpackage

>>> src/atf_cell.sv
// ----------------------------------------------------------------------------
// atf_cell
// One byte slot of the frame shift row: loads a frame word in parallel or
// takes the word of its upstream neighbor on every shift.
// ----------------------------------------------------------------------------
module atf_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_shift,
    input  atf_pkg::t_cell i_load_cell,
    input  atf_pkg::t_cell i_next_cell,
    output atf_pkg::t_cell o_cell
);
    import atf_pkg::*;

    t_cell r_cell;
    t_cell n_cell;

    always_comb begin
        n_cell = r_cell;
        if (i_load) begin
            n_cell = i_load_cell;
        end else if (i_shift) begin
            n_cell = i_next_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

>>> src/attitude_telemetry_framer.sv
// ----------------------------------------------------------------------------
// attitude_telemetry_framer
// First frame byte is shown in the cycle after an item is accepted.
// Output: one frame byte per cycle while i_stall is low, through an
// 18-cell shift row; the next item loads as the closing byte leaves.
// Checksum builds up as data bytes shift into the output cell.
// Reset: synchronous active low, empties the row; no frame is pending.
// ----------------------------------------------------------------------------
module attitude_telemetry_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_yaw_tenths,
    input  logic [15:0] i_pitch_tenths,
    input  logic [15:0] i_roll_tenths,
    input  logic [15:0] i_altitude_tenths,
    input  logic [15:0] i_temperature_tenths,
    input  logic [15:0] i_pressure_tens,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end
);
    import atf_pkg::*;

    t_cell       cells     [FRAME_LEN];
    t_cell       load_row  [FRAME_LEN];
    t_cell       next_row  [FRAME_LEN];
    logic [15:0] sm_vals   [NUM_VALUES];
    logic [7:0]  r_sum;
    logic [7:0]  n_sum;
    logic        shift;
    logic        load;

    assign shift   = cells[0].valid && !i_stall;
    assign o_stall = cells[0].valid && !(shift && !cells[1].valid);
    assign load    = i_valid && !o_stall;

    assign sm_vals[0] = to_sign_mag(i_yaw_tenths);
    assign sm_vals[1] = to_sign_mag(i_pitch_tenths);
    assign sm_vals[2] = to_sign_mag(i_roll_tenths);
    assign sm_vals[3] = to_sign_mag(i_altitude_tenths);
    assign sm_vals[4] = to_sign_mag(i_temperature_tenths);
    assign sm_vals[5] = to_sign_mag(i_pressure_tens);

    // parallel load image of one frame
    always_comb begin
        for (int i = 0; i < FRAME_LEN; i++) begin
            load_row[i] = '{valid: 1'b1, sum_en: 1'b0, csum: 1'b0, last: 1'b0,
                            data: 8'h00};
        end
        load_row[0].data = SYNC_A;
        load_row[1].data = SYNC_B;
        load_row[2].data = LEN_BYTE;
        load_row[3].data = ID_BYTE;
        for (int j = 0; j < NUM_VALUES; j++) begin
            load_row[HEAD_LEN + 2*j].data       = sm_vals[j][15:8];
            load_row[HEAD_LEN + 2*j].sum_en     = 1'b1;
            load_row[HEAD_LEN + 2*j + 1].data   = sm_vals[j][7:0];
            load_row[HEAD_LEN + 2*j + 1].sum_en = 1'b1;
        end
        load_row[FRAME_LEN-2].csum = 1'b1;
        load_row[FRAME_LEN-1].data = END_BYTE;
        load_row[FRAME_LEN-1].last = 1'b1;
    end

    // neighbor hand-off, checksum substituted on entry to the output cell
    always_comb begin
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            next_row[i] = cells[i+1];
        end
        next_row[FRAME_LEN-1] = '0;
        if (cells[1].csum) begin
            next_row[0].data = r_sum;
        end
    end

    always_comb begin
        n_sum = r_sum;
        if (load) begin
            n_sum = SUM_SEED;
        end else if (shift && cells[1].valid && cells[1].sum_en) begin
            n_sum = r_sum + cells[1].data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    for (genvar g = 0; g < FRAME_LEN; g++) begin : g_cell
        atf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (load),
            .i_shift     (shift),
            .i_load_cell (load_row[g]),
            .i_next_cell (next_row[g]),
            .o_cell      (cells[g])
        );
    end

    assign o_valid      = cells[0].valid;
    assign o_frame_byte = cells[0].data;
    assign o_frame_end  = cells[0].last;

`ifndef SYNTHESIS
    a_load_shows_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_valid && o_frame_byte == SYNC_A && !o_frame_end))
        else $error("frame did not start with sync byte");

    a_end_is_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> !cells[1].valid)
        else $error("word queued behind closing byte");

    a_row_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cells[1].valid |-> cells[0].valid)
        else $error("gap at head of shift row");

    a_no_load_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cells[1].valid && !o_frame_end) |-> o_stall)
        else $error("input taken while frame in flight");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for attitude_telemetry_framer. Six signed attitude values go in
// per word; an in-bench predictor recodes them to sign-magnitude and builds
// the 18-byte frame with checksum, and a checker compares every output byte
// and end flag in order. Runs corner values, back-to-back traffic, a drain
// pause and random traffic with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import atf_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [15:0] altitude;
        logic [15:0] temperature;
        logic [15:0] pressure;
    } t_attitude;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic        i_clk                = 1'b0;
    logic        i_rst_n              = 1'b0;
    logic        i_valid              = 1'b0;
    logic        i_stall              = 1'b0;
    logic [15:0] i_yaw_tenths         = '0;
    logic [15:0] i_pitch_tenths       = '0;
    logic [15:0] i_roll_tenths        = '0;
    logic [15:0] i_altitude_tenths    = '0;
    logic [15:0] i_temperature_tenths = '0;
    logic [15:0] i_pressure_tens      = '0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_frame_byte;
    logic        o_frame_end;

    t_frame_byte pending_frame_bytes[$];
    int          error_count    = 0;
    int          samples_taken  = 0;
    int          bytes_checked  = 0;
    int          idle_cycles    = 0;
    int          stall_run      = 0;
    logic        stall_on       = 1'b0;
    int          gap_on         = 0;

    wire in_fire  = i_rst_n && i_valid && !o_stall;
    wire out_fire = i_rst_n && (o_valid === 1'b1) && (i_stall === 1'b0);

    attitude_telemetry_framer uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_yaw_tenths         (i_yaw_tenths),
        .i_pitch_tenths       (i_pitch_tenths),
        .i_roll_tenths        (i_roll_tenths),
        .i_altitude_tenths    (i_altitude_tenths),
        .i_temperature_tenths (i_temperature_tenths),
        .i_pressure_tens      (i_pressure_tens),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_frame_byte         (o_frame_byte),
        .o_frame_end          (o_frame_end)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return $urandom_range(0, 2);
        if (r < 18) return $urandom_range(3, 8);
        return $urandom_range(20, 45);
    endfunction

    function automatic logic [15:0] rand_value();
        int          r;
        logic [15:0] mag;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 5))
                0: return 16'h0000;
                1: return 16'h7FFF;
                2: return 16'h8000;
                3: return 16'hFFFF;
                4: return 16'h8001;
                default: return 16'h0001;
            endcase
        end
        if (r < 3) begin
            mag = 16'($urandom_range(0, 3600));
            if ($urandom_range(0, 1) == 1) return -mag;
            return mag;
        end
        return 16'($urandom());
    endfunction

    function automatic t_attitude random_attitude();
        return {rand_value(), rand_value(), rand_value(),
                rand_value(), rand_value(), rand_value()};
    endfunction

    function automatic logic [15:0] sign_magnitude(input logic [15:0] v);
        logic [15:0] neg;
        if (!v[15]) return v;
        // most negative value folds onto zero
        if (v == 16'h8000) return 16'h0000;
        neg = -v;
        return {1'b1, neg[14:0]};
    endfunction

    function automatic void push_frame_byte(input logic [7:0] data, input logic last);
        t_frame_byte fb;
        fb.data = data;
        fb.last = last;
        pending_frame_bytes.push_back(fb);
    endfunction

    function automatic void queue_frame(input t_attitude a);
        logic [15:0] words [NUM_VALUES];
        logic [15:0] code;
        logic [7:0]  sum;
        words[0] = a.yaw;
        words[1] = a.pitch;
        words[2] = a.roll;
        words[3] = a.altitude;
        words[4] = a.temperature;
        words[5] = a.pressure;
        push_frame_byte(SYNC_A, 1'b0);
        push_frame_byte(SYNC_B, 1'b0);
        push_frame_byte(LEN_BYTE, 1'b0);
        push_frame_byte(ID_BYTE, 1'b0);
        sum = SUM_SEED;
        for (int k = 0; k < NUM_VALUES; k++) begin
            code = sign_magnitude(words[k]);
            push_frame_byte(code[15:8], 1'b0);
            push_frame_byte(code[7:0], 1'b0);
            sum = sum + code[15:8] + code[7:0];
        end
        push_frame_byte(sum, 1'b0);
        push_frame_byte(END_BYTE, 1'b1);
    endfunction

    // predictor on input handshakes, compare on output handshakes
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (in_fire) begin
            queue_frame({i_yaw_tenths, i_pitch_tenths, i_roll_tenths,
                         i_altitude_tenths, i_temperature_tenths, i_pressure_tens});
            samples_taken++;
        end
        if (out_fire) begin
            if (pending_frame_bytes.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual byte %02h end %0b",
                         $time, o_frame_byte, o_frame_end);
                error_count++;
            end else begin
                want = pending_frame_bytes.pop_front();
                if (o_frame_byte !== want.data) begin
                    $display("%0t: frame byte %0d: expected %02h, actual %02h",
                             $time, bytes_checked % FRAME_LEN, want.data, o_frame_byte);
                    error_count++;
                end
                if (o_frame_end !== want.last) begin
                    $display("%0t: frame end at byte %0d: expected %0b, actual %0b",
                             $time, bytes_checked % FRAME_LEN, want.last, o_frame_end);
                    error_count++;
                end
                bytes_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
            i_stall   <= 1'b1;
        end else if (stall_on && $urandom_range(0, 2) == 0) begin
            stall_run <= pick_gap();
            i_stall   <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (in_fire || out_fire) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no word moved for %0d cycles", $time, idle_cycles);
            $display("attitude_telemetry_framer regression: fail");
            $finish;
        end
    end

    task automatic send_attitude(input t_attitude a);
        int gap;
        gap = gap_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid              <= 1'b1;
        i_yaw_tenths         <= a.yaw;
        i_pitch_tenths       <= a.pitch;
        i_roll_tenths        <= a.roll;
        i_altitude_tenths    <= a.altitude;
        i_temperature_tenths <= a.temperature;
        i_pressure_tens      <= a.pressure;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_for_frames();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_frame_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_corner_values();
        stall_on <= 1'b0;
        gap_on = 0;
        send_attitude({6{16'h0000}});
        send_attitude({6{16'h7FFF}});
        send_attitude({6{16'h8000}});
        send_attitude({6{16'hFFFF}});
        send_attitude({6{16'h0001}});
        send_attitude({6{16'h8001}});
        // most negative against zero
        send_attitude({16'h8000, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h0000});
        send_attitude({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        send_attitude({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
        send_attitude({16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h8001, 16'h0001});
        // checksum wraps several times
        send_attitude({6{16'h7F7F}});
        send_attitude({16'd3599, 16'hFC7C, 16'd1800, 16'hFF88, 16'hFE70, 16'd10132});
        gap_on = 1;
        stall_on <= 1'b1;
        send_attitude({16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001});
    endtask

    task automatic test_back_to_back();
        stall_on <= 1'b0;
        gap_on = 0;
        repeat (20) send_attitude(random_attitude());
    endtask

    task automatic test_drain_pause();
        stall_on <= 1'b1;
        gap_on = 1;
        repeat (2) begin
            repeat (8) send_attitude(random_attitude());
            wait_for_frames();
        end
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 60; n++) begin
            // quiet stretch at the start of every twenty
            gap_on = (n % 20 < 5) ? 0 : 1;
            stall_on <= (n % 20 >= 5);
            send_attitude(random_attitude());
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_values();
        test_back_to_back();
        test_drain_pause();
        test_random_traffic();
        wait_for_frames();
        repeat (40) @(posedge i_clk);
        $display("covered %0d attitude samples, %0d frame bytes checked", samples_taken,
                 bytes_checked);
        $display("corner values, back-to-back words, drain pause, random gaps and stalls");
        if (error_count == 0) begin
            $display("attitude_telemetry_framer regression: pass");
        end else begin
            $display("attitude_telemetry_framer regression: fail");
        end
        $finish;
    end

endmodule

>>> attitude_telemetry_framer.f
src/atf_pkg.sv
src/atf_cell.sv
src/attitude_telemetry_framer.sv
bench/testbench.sv
